// ===== src/psu_pkg.sv =====
// Shared types and constants for the particle swarm update block.
package psu_pkg;
   localparam int MaxParticles = 64;
   localparam int IdxW = $clog2(MaxParticles);
   localparam int CntW = IdxW + 1;
   localparam int CoefFrac = 14;
   localparam int RandFrac = 16;

   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_FIT  = 2'd1;
   localparam logic [1:0] KIND_MOVE = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd3;

   localparam logic [1:0] CSR_C1  = 2'd0;
   localparam logic [1:0] CSR_C2  = 2'd1;
   localparam logic [1:0] CSR_W   = 2'd2;
   localparam logic [1:0] CSR_ACT = 2'd3;

   typedef logic signed [31:0] word_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch input beat, issue memory read
      logic setup;     // latch memory read data, form coefficients
      logic dim_mul;   // multiply stage for current dimension
      logic dim_acc;   // accumulate and write back current dimension
      logic [1:0] dim;
      logic commit;    // write memories, load result register
   } cmd_type;

   typedef struct packed {
      logic reject;
   } sts_type;
endpackage

// ===== src/psu_datapath.sv =====
// Particle memories, best tracking and the per-dimension update arithmetic.
module psu_datapath import psu_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  cmd_type cmd,
   output sts_type sts,
   input  logic csr_write,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_data,
   input  logic [1:0] req_kind,
   input  logic [IdxW-1:0] req_particle_index,
   input  word_type req_load_x,
   input  word_type req_load_y,
   input  word_type req_load_z,
   input  word_type req_fitness_value,
   input  logic [15:0] req_rand_personal,
   input  logic [15:0] req_rand_global,
   output logic [IdxW-1:0] rsp_out_index,
   output word_type rsp_pos_x,
   output word_type rsp_pos_y,
   output word_type rsp_pos_z,
   output word_type rsp_swarm_best_cost,
   output logic rsp_swarm_best_valid,
   output logic rsp_personal_improved,
   output logic rsp_swarm_improved,
   output logic rsp_saturated,
   output logic rsp_status
);
   logic [15:0] c1_ff, c2_ff, w_ff;
   logic [6:0] act_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= 16'd6717;
         c2_ff <= 16'd8520;
         w_ff <= 16'd16384;
         act_ff <= 7'd64;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_C1:  c1_ff <= csr_data;
            CSR_C2:  c2_ff <= csr_data;
            CSR_W:   w_ff <= csr_data;
            CSR_ACT: act_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // Particle memories: one row per particle, synchronous read.
   logic [95:0] pos_mem [MaxParticles];
   logic [95:0] vel_mem [MaxParticles];
   logic [95:0] pbp_mem [MaxParticles];
   logic [31:0] pbc_mem [MaxParticles];
   logic [MaxParticles-1:0] pbv_ff;

   logic [1:0] kind_ff;
   logic [IdxW-1:0] idx_ff;
   logic [95:0] load_ff;
   word_type fit_ff;
   logic [15:0] r1_ff, r2_ff;
   logic rej_ff;
   logic [95:0] pos_rd_ff, vel_rd_ff, pbp_rd_ff;
   word_type pbc_rd_ff;

   logic [CntW-1:0] limit;
   assign limit = (act_ff > 7'(MaxParticles)) ? CntW'(MaxParticles) : CntW'(act_ff);
   assign sts.reject = rej_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         idx_ff <= req_particle_index;
         load_ff <= {req_load_z, req_load_y, req_load_x};
         fit_ff <= req_fitness_value;
         r1_ff <= req_rand_personal;
         r2_ff <= req_rand_global;
         rej_ff <= {1'b0, req_particle_index} >= limit;
         pos_rd_ff <= pos_mem[req_particle_index];
         vel_rd_ff <= vel_mem[req_particle_index];
         pbp_rd_ff <= pbp_mem[req_particle_index];
         pbc_rd_ff <= pbc_mem[req_particle_index];
      end
   end

   // Coefficients and working copies.
   logic [15:0] k1_ff, k2_ff;
   logic [95:0] x_ff, v_ff, pbx_ff;
   logic pb_ok_ff;
   logic sat_ff;

   logic [31:0] k1p, k2p;
   assign k1p = c1_ff * r1_ff;
   assign k2p = c2_ff * r2_ff;

   // Per-dimension multiply stage.
   word_type xd, vd, pd, gd;
   logic signed [48:0] tw_ff, t1_ff, t2_ff;
   logic signed [32:0] dp, dg;
   assign xd = x_ff[cmd.dim*32 +: 32];
   assign vd = v_ff[cmd.dim*32 +: 32];
   assign pd = pbx_ff[cmd.dim*32 +: 32];
   logic [95:0] gpos_ff;
   word_type gcost_ff;
   logic gflag_ff;
   assign gd = gpos_ff[cmd.dim*32 +: 32];
   assign dp = 33'(pd) - 33'(xd);
   assign dg = 33'(gd) - 33'(xd);

   // widen both operands so the full product is kept
   always_ff @(posedge clock) begin
      if (cmd.dim_mul) begin
         tw_ff <= 49'($signed({1'b0, w_ff})) * 49'(vd);
         t1_ff <= pb_ok_ff ? 49'($signed({1'b0, k1_ff})) * 49'(dp) : '0;
         t2_ff <= gflag_ff ? 49'($signed({1'b0, k2_ff})) * 49'(dg) : '0;
      end
   end

   logic signed [50:0] tsum;
   logic signed [36:0] tsh;
   logic signed [32:0] nx;
   word_type nv, nxc;
   logic sv, sx;
   assign tsum = 51'(tw_ff) + 51'(t1_ff) + 51'(t2_ff);
   assign tsh = 37'(tsum >>> CoefFrac);
   always_comb begin
      sv = 1'b0;
      if (tsh > 37'sh7FFFFFFF) begin
         nv = 32'sh7FFFFFFF; sv = 1'b1;
      end else if (tsh < -37'sh80000000) begin
         nv = 32'sh80000000; sv = 1'b1;
      end else begin
         nv = tsh[31:0];
      end
      nx = 33'(xd) + 33'(nv);
      sx = 1'b0;
      if (nx > 33'sh7FFFFFFF) begin
         nxc = 32'sh7FFFFFFF; sx = 1'b1;
      end else if (nx < -33'sh80000000) begin
         nxc = 32'sh80000000; sx = 1'b1;
      end else begin
         nxc = nx[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         k1_ff <= k1p[31:RandFrac];
         k2_ff <= k2p[31:RandFrac];
         x_ff <= pos_rd_ff;
         v_ff <= vel_rd_ff;
         pbx_ff <= pbp_rd_ff;
         pb_ok_ff <= pbv_ff[idx_ff];
         sat_ff <= 1'b0;
      end else if (cmd.dim_acc) begin
         v_ff[cmd.dim*32 +: 32] <= nv;
         x_ff[cmd.dim*32 +: 32] <= nxc;
         sat_ff <= sat_ff | sv | sx;
      end
   end

   // Fitness decisions.
   logic pimp, simp;
   word_type new_pbc;
   logic [95:0] new_pbp;
   always_comb begin
      pimp = !pbv_ff[idx_ff] || (fit_ff < $signed(pbc_rd_ff));
      new_pbc = pimp ? fit_ff : pbc_rd_ff;
      new_pbp = pimp ? pos_rd_ff : pbp_rd_ff;
      simp = !gflag_ff || (new_pbc < gcost_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pbv_ff <= '0;
         gflag_ff <= 1'b0;
         gcost_ff <= '0;
         gpos_ff <= '0;
      end else if (cmd.commit && !rej_ff) begin
         if (kind_ff == KIND_LOAD) pbv_ff[idx_ff] <= 1'b0;
         if (kind_ff == KIND_FIT) begin
            pbv_ff[idx_ff] <= 1'b1;
            if (simp) begin
               gflag_ff <= 1'b1;
               gcost_ff <= new_pbc;
               gpos_ff <= new_pbp;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && !rej_ff) begin
         if (kind_ff == KIND_LOAD) begin
            pos_mem[idx_ff] <= load_ff;
            vel_mem[idx_ff] <= '0;
         end
         if (kind_ff == KIND_FIT && pimp) begin
            pbc_mem[idx_ff] <= fit_ff;
            pbp_mem[idx_ff] <= pos_rd_ff;
         end
         if (kind_ff == KIND_MOVE) begin
            pos_mem[idx_ff] <= x_ff;
            vel_mem[idx_ff] <= v_ff;
         end
      end
   end

   // Result register.
   logic [95:0] rpos;
   always_comb begin
      case (kind_ff)
         KIND_LOAD: rpos = load_ff;
         KIND_MOVE: rpos = x_ff;
         default:   rpos = pos_rd_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_out_index <= idx_ff;
         rsp_status <= rej_ff;
         rsp_pos_x <= rej_ff ? '0 : rpos[31:0];
         rsp_pos_y <= rej_ff ? '0 : rpos[63:32];
         rsp_pos_z <= rej_ff ? '0 : rpos[95:64];
         rsp_personal_improved <= !rej_ff && kind_ff == KIND_FIT && pimp;
         rsp_swarm_improved <= !rej_ff && kind_ff == KIND_FIT && simp;
         rsp_saturated <= !rej_ff && kind_ff == KIND_MOVE && sat_ff;
         if (!rej_ff && kind_ff == KIND_FIT && simp) begin
            rsp_swarm_best_cost <= new_pbc;
            rsp_swarm_best_valid <= 1'b1;
         end else begin
            rsp_swarm_best_cost <= gcost_ff;
            rsp_swarm_best_valid <= gflag_ff;
         end
      end
   end
endmodule

// ===== src/psu_control.sv =====
// Sequencer for one item: capture, setup, three dimension passes, commit, deliver.
module psu_control import psu_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   output logic rsp_valid,
   input  logic rsp_stall,
   output cmd_type cmd
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_MUL = 3'd2;
   localparam logic [2:0] ST_ACC = 3'd3;
   localparam logic [2:0] ST_COMMIT = 3'd4;
   localparam logic [2:0] ST_OUT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] dim_ff, dim_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      state_in = state_ff;
      dim_in = dim_ff;
      cmd = '0;
      cmd.dim = dim_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            dim_in = 2'd0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.dim_mul = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.dim_acc = 1'b1;
            if (dim_ff == 2'd2) begin
               state_in = ST_COMMIT;
            end else begin
               dim_in = dim_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dim_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         dim_ff <= dim_in;
      end
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.capture, cmd.setup, cmd.dim_mul, cmd.dim_acc, cmd.commit}) <= 1)
      else $error("more than one datapath command");
   a_commit_out: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid) else $error("commit without result");
   a_acc_after_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.dim_acc |-> $past(cmd.dim_mul)) else $error("accumulate without multiply");
endmodule

// ===== src/particle_swarm_update.sv =====
// Top level of the particle swarm update block.
// Each item passes through capture, setup, three dimension passes of the shared
// multiply/accumulate unit, commit and the response beat; a new request is taken only
// in the idle slot after the previous response beat is accepted, so items do not overlap.
// Reset clears the sequencer, personal-best valid bits, swarm best and configuration registers;
// particle memories hold no reset value.
module particle_swarm_update import psu_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_kind,
   input  logic [IdxW-1:0] req_particle_index,
   input  word_type req_load_x,
   input  word_type req_load_y,
   input  word_type req_load_z,
   input  word_type req_fitness_value,
   input  logic [15:0] req_rand_personal,
   input  logic [15:0] req_rand_global,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [IdxW-1:0] rsp_out_index,
   output word_type rsp_pos_x,
   output word_type rsp_pos_y,
   output word_type rsp_pos_z,
   output word_type rsp_swarm_best_cost,
   output logic rsp_swarm_best_valid,
   output logic rsp_personal_improved,
   output logic rsp_swarm_improved,
   output logic rsp_saturated,
   output logic rsp_status
);
   cmd_type cmd;
   sts_type sts;

   psu_control u_ctl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .cmd
   );

   psu_datapath u_dp (
      .clock, .reset, .cmd, .sts, .csr_write, .csr_index, .csr_data,
      .req_kind, .req_particle_index, .req_load_x, .req_load_y, .req_load_z,
      .req_fitness_value, .req_rand_personal, .req_rand_global,
      .rsp_out_index, .rsp_pos_x, .rsp_pos_y, .rsp_pos_z, .rsp_swarm_best_cost,
      .rsp_swarm_best_valid, .rsp_personal_improved, .rsp_swarm_improved,
      .rsp_saturated, .rsp_status
   );

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_personal_improved && !rsp_saturated
         && rsp_pos_x == 0) else $error("rejected beat carries data");
   a_improve_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_swarm_improved |-> rsp_swarm_best_valid)
      else $error("swarm improved without valid best");
   a_reject_seen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> sts.reject) else $error("status mismatch");
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the particle swarm update block.
module tb;
   import psu_pkg::*;

   localparam int IdleLimit = 6000;
   localparam int SettleCycles = 12;

   typedef struct packed {
      logic [IdxW-1:0] index;
      word_type x;
      word_type y;
      word_type z;
      word_type best_cost;
      logic best_valid;
      logic pers_imp;
      logic swarm_imp;
      logic sat;
      logic status;
   } swarm_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = CSR_C1;
   logic [15:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_kind = KIND_LOAD;
   logic [IdxW-1:0] req_particle_index = '0;
   word_type req_load_x = '0;
   word_type req_load_y = '0;
   word_type req_load_z = '0;
   word_type req_fitness_value = '0;
   logic [15:0] req_rand_personal = '0;
   logic [15:0] req_rand_global = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   swarm_rsp_t seen;

   particle_swarm_update i_dut (.*, .rsp_out_index(seen.index), .rsp_pos_x(seen.x),
      .rsp_pos_y(seen.y), .rsp_pos_z(seen.z), .rsp_swarm_best_cost(seen.best_cost),
      .rsp_swarm_best_valid(seen.best_valid), .rsp_personal_improved(seen.pers_imp),
      .rsp_swarm_improved(seen.swarm_imp), .rsp_saturated(seen.sat),
      .rsp_status(seen.status));

   always #5 clock = ~clock;

   // mirror of the swarm state
   logic [15:0] c1_q, c2_q, w_q;
   logic [6:0] act_q;
   word_type pos_m [MaxParticles][3];
   word_type vel_m [MaxParticles][3];
   word_type pb_pos [MaxParticles][3];
   word_type pb_cost [MaxParticles];
   logic pb_ok [MaxParticles];
   logic loaded [MaxParticles];
   word_type sb_pos [3];
   word_type sb_cost;
   logic sb_ok;

   swarm_rsp_t pending_rsp [$];
   int errors = 0;
   int hold_left = 0;
   logic steady = 1'b0;
   int idle_cnt = 0;

   function automatic word_type clip_word(longint t, inout logic sat);
      if (t > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7FFFFFFF;
      end
      if (t < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return word_type'(t);
   endfunction

   function automatic swarm_rsp_t update_swarm(logic [1:0] kind, int idx, word_type lx,
         word_type ly, word_type lz, word_type fit, logic [15:0] r1, logic [15:0] r2);
      swarm_rsp_t r;
      int limit;
      longint k1, k2, t, x;
      word_type ld [3];
      r = '0;
      r.index = IdxW'(idx);
      limit = (act_q < MaxParticles) ? act_q : MaxParticles;
      ld[0] = lx; ld[1] = ly; ld[2] = lz;
      if (idx >= limit) begin
         r.best_cost = sb_cost;
         r.best_valid = sb_ok;
         r.status = 1'b1;
         return r;
      end
      case (kind)
         KIND_LOAD: begin
            for (int d = 0; d < 3; d++) begin
               pos_m[idx][d] = ld[d];
               vel_m[idx][d] = '0;
            end
            pb_ok[idx] = 1'b0;
         end
         KIND_FIT: begin
            if (!pb_ok[idx] || fit < pb_cost[idx]) begin
               pb_cost[idx] = fit;
               for (int d = 0; d < 3; d++) pb_pos[idx][d] = pos_m[idx][d];
               pb_ok[idx] = 1'b1;
               r.pers_imp = 1'b1;
            end
            if (!sb_ok || pb_cost[idx] < sb_cost) begin
               sb_cost = pb_cost[idx];
               for (int d = 0; d < 3; d++) sb_pos[d] = pb_pos[idx][d];
               sb_ok = 1'b1;
               r.swarm_imp = 1'b1;
            end
         end
         KIND_MOVE: begin
            k1 = (longint'(c1_q) * longint'(r1)) >>> RandFrac;
            k2 = (longint'(c2_q) * longint'(r2)) >>> RandFrac;
            for (int d = 0; d < 3; d++) begin
               x = pos_m[idx][d];
               t = longint'(w_q) * longint'(vel_m[idx][d]);
               if (pb_ok[idx]) t += k1 * (longint'(pb_pos[idx][d]) - x);
               if (sb_ok) t += k2 * (longint'(sb_pos[d]) - x);
               vel_m[idx][d] = clip_word(t >>> CoefFrac, r.sat);
               pos_m[idx][d] = clip_word(x + longint'(vel_m[idx][d]), r.sat);
            end
         end
         default: ;
      endcase
      r.x = pos_m[idx][0];
      r.y = pos_m[idx][1];
      r.z = pos_m[idx][2];
      r.best_cost = sb_cost;
      r.best_valid = sb_ok;
      return r;
   endfunction

   // send one beat; entered and left at a rising edge
   task automatic send_item(logic [1:0] kind, int idx, word_type lx, word_type ly,
         word_type lz, word_type fit, logic [15:0] r1, logic [15:0] r2);
      // never touch a particle that was not loaded: turn such items into loads
      if (kind != KIND_LOAD && !loaded[idx] && idx < act_q) kind = KIND_LOAD;
      while (!steady && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_particle_index <= IdxW'(idx);
      req_load_x <= lx;
      req_load_y <= ly;
      req_load_z <= lz;
      req_fitness_value <= fit;
      req_rand_personal <= r1;
      req_rand_global <= r2;
      do @(posedge clock); while (req_stall);
      if (kind == KIND_LOAD && idx < act_q) loaded[idx] = 1'b1;
      pending_rsp.push_back(update_swarm(kind, idx, lx, ly, lz, fit, r1, r2));
   endtask

   function automatic word_type rand_word();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(2000)) - 1000;
         2: return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
         default: return $urandom_range(1) ? 32'sh7FFFFFF0 + $urandom_range(15)
                                           : 32'sh80000000 + $urandom_range(15);
      endcase
   endfunction

   task automatic send_random(int count);
      int roll;
      logic [1:0] kind;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         kind = roll < 20 ? KIND_LOAD : roll < 55 ? KIND_FIT : roll < 95 ? KIND_MOVE
            : KIND_NONE;
         send_item(kind, $urandom_range(MaxParticles - 1), rand_word(), rand_word(),
            rand_word(), rand_word(), 16'($urandom), 16'($urandom));
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [15:0] data);
      drain();
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (index)
         CSR_C1: c1_q = data;
         CSR_C2: c2_q = data;
         CSR_W: w_q = data;
         default: act_q = data[6:0];
      endcase
   endtask

   task automatic test_directed();
      send_item(KIND_LOAD, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0);
      send_item(KIND_LOAD, 1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 0);
      send_item(KIND_LOAD, 63, 0, 32'sh0001_0000, -32'sh0001_0000, 0, 0, 0);
      // move with no bests held: no pull at all
      send_item(KIND_MOVE, 63, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF);
      send_item(KIND_FIT, 0, 0, 0, 0, 32'sh80000000, 0, 0);
      send_item(KIND_FIT, 0, 0, 0, 0, 32'sh80000000, 0, 0);
      send_item(KIND_FIT, 1, 0, 0, 0, 32'sh7FFFFFFF, 0, 0);
      send_item(KIND_FIT, 1, 0, 0, 0, 32'sh7FFFFFFE, 0, 0);
      // full pull toward the far corner clips
      send_item(KIND_MOVE, 1, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF);
      send_item(KIND_MOVE, 1, 0, 0, 0, 0, 16'h0000, 16'h0000);
      send_item(KIND_MOVE, 63, 0, 0, 0, 0, 16'h8000, 16'hFFFF);
      send_item(KIND_FIT, 63, 0, 0, 0, 32'sh0000_0001, 0, 0);
      send_item(KIND_NONE, 63, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
         '1, '1);
      send_item(KIND_LOAD, 1, 32'sh0000_1234, 32'sh0, -32'sh1, 0, 0, 0);
      send_item(KIND_MOVE, 1, 0, 0, 0, 0, 16'hFFFF, 16'h0001);
   endtask

   task automatic test_coefficients();
      write_reg(CSR_C1, 16'hFFFF);
      write_reg(CSR_C2, 16'hFFFF);
      write_reg(CSR_W, 16'hFFFF);
      send_random(200);
      write_reg(CSR_C1, 16'h0000);
      write_reg(CSR_C2, 16'h0000);
      write_reg(CSR_W, 16'h0000);
      send_random(200);
      write_reg(CSR_C1, 16'd6717);
      write_reg(CSR_C2, 16'd8520);
      write_reg(CSR_W, 16'd12000);
      send_random(200);
   endtask

   task automatic test_active_limit();
      write_reg(CSR_ACT, 16'd0);
      send_random(60);
      write_reg(CSR_ACT, 16'hFF81);
      send_random(150);
      write_reg(CSR_ACT, 16'd37);
      send_random(200);
      write_reg(CSR_ACT, 16'd127);
      send_random(150);
      write_reg(CSR_ACT, 16'd64);
   endtask

   task automatic test_backpressure();
      hold_left = 400;
      send_random(120);
   endtask

   task automatic test_streaming();
      steady = 1'b1;
      send_random(250);
      steady = 1'b0;
      send_random(400);
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && $urandom_range(99) < 17;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response beat %p", seen);
         end else if (seen !== pending_rsp[0]) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", pending_rsp[0], seen);
            void'(pending_rsp.pop_front());
         end else begin
            void'(pending_rsp.pop_front());
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         idle_cnt <= 0;
      end else if (idle_cnt >= IdleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cnt <= idle_cnt + 1;
      end
   end

   initial begin
      c1_q = 16'd6717;
      c2_q = 16'd8520;
      w_q = 16'd16384;
      act_q = 7'd64;
      sb_cost = '0;
      sb_ok = 1'b0;
      for (int i = 0; i < 3; i++) sb_pos[i] = '0;
      for (int i = 0; i < MaxParticles; i++) begin
         pb_ok[i] = 1'b0;
         loaded[i] = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_coefficients();
      test_active_limit();
      test_streaming();
      drain();
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
